/* rtl/pdbd_pkg.sv */
//------------------------------------------------------------------------------
// pdbd_pkg
// Shared types and constants of the parking distance bar display.
//------------------------------------------------------------------------------
`default_nettype none
package pdbd_pkg;
   localparam int LedCountDefault    = 60;
   localparam int FlashPeriodDefault = 250;

   localparam logic [2:0] REG_FAR_START  = 3'd0;
   localparam logic [2:0] REG_GOOD_START = 3'd1;
   localparam logic [2:0] REG_GOOD_END   = 3'd2;
   localparam logic [2:0] REG_OK_END     = 3'd3;
   localparam logic [2:0] REG_STOP_LIMIT = 3'd4;
   localparam logic [2:0] REG_TIMEOUT    = 3'd5;
   localparam logic [2:0] REG_REFRESH    = 3'd6;
   localparam logic [2:0] REG_MOTION     = 3'd7;

   localparam logic [2:0] COLOR_BLACK    = 3'd0;
   localparam logic [2:0] COLOR_STOP_ON  = 3'd5;
   localparam logic [2:0] COLOR_STOP_OFF = 3'd6;
   localparam logic [2:0] COLOR_ERROR    = 3'd7;

   localparam logic [2:0] ZONE_FAR   = 3'd0;
   localparam logic [2:0] ZONE_STOP  = 3'd5;
   localparam logic [2:0] ZONE_ERROR = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_SQ, ST_CUBE, ST_MUL, ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic div_step;
      logic do_sq;
      logic do_cube;
      logic do_mul;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic frame;
      logic need_split;
      logic div_done;
      logic out_busy;
   } sts_type;
endpackage
`default_nettype wire

/* rtl/parking_distance_bar_display.sv */
//------------------------------------------------------------------------------
// parking_distance_bar_display
// Frame generator for a parking distance LED bar.
//------------------------------------------------------------------------------
// One request word is one millisecond tick. Ticks that end no refresh period,
// and frames in zones 0, 5 and 6 or blanked, end in the accepting state; a frame
// in zones 1 to 4 goes on through the 16-step serial divider, then the square,
// cubic, scaling multiply and output stages. The result sits in an output
// register, so the next tick is taken once that register can be refilled.
`default_nettype none
module parking_distance_bar_display
   import pdbd_pkg::*;
#(
   parameter int LED_COUNT       = LedCountDefault,
   parameter int FLASH_PERIOD_MS = FlashPeriodDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // distance[15:0], change_rate[31:16]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // lit, zone, split_count, lower_color, upper_color
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   logic [15:0] far_ff, gstart_ff, gend_ff, ok_ff, stop_ff;
   logic [23:0] timeout_ff;
   logic [9:0]  refresh_ff;
   logic [14:0] motion_ff;
   logic [2:0]  idx;
   cmd_type     cmd;
   sts_type     sts;

   assign csr_pready = 1'b1;
   assign idx = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         far_ff <= 16'd25600; gstart_ff <= 16'd19200; gend_ff <= 16'd12800;
         ok_ff <= 16'd7680; stop_ff <= 16'd3840; timeout_ff <= 24'd300000;
         refresh_ff <= 10'd100; motion_ff <= 15'd64;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (idx)
            REG_FAR_START:  far_ff     <= csr_pwdata[15:0];
            REG_GOOD_START: gstart_ff  <= csr_pwdata[15:0];
            REG_GOOD_END:   gend_ff    <= csr_pwdata[15:0];
            REG_OK_END:     ok_ff      <= csr_pwdata[15:0];
            REG_STOP_LIMIT: stop_ff    <= csr_pwdata[15:0];
            REG_TIMEOUT:    timeout_ff <= csr_pwdata[23:0];
            REG_REFRESH:    refresh_ff <= csr_pwdata[9:0];
            REG_MOTION:     motion_ff  <= csr_pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_FAR_START:  csr_prdata = {16'd0, far_ff};
         REG_GOOD_START: csr_prdata = {16'd0, gstart_ff};
         REG_GOOD_END:   csr_prdata = {16'd0, gend_ff};
         REG_OK_END:     csr_prdata = {16'd0, ok_ff};
         REG_STOP_LIMIT: csr_prdata = {16'd0, stop_ff};
         REG_TIMEOUT:    csr_prdata = {8'd0, timeout_ff};
         REG_REFRESH:    csr_prdata = {22'd0, refresh_ff};
         REG_MOTION:     csr_prdata = {17'd0, motion_ff};
         default:        csr_prdata = '0;
      endcase
   end

   pdbd_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .sts(sts), .cmd(cmd)
   );

   pdbd_datapath #(.LED_COUNT(LED_COUNT), .FLASH_PERIOD_MS(FLASH_PERIOD_MS)) u_dp (
      .clock(clock), .reset(reset),
      .distance(req_tdata[15:0]), .change_rate(req_tdata[31:16]),
      .far_start(far_ff), .good_start(gstart_ff), .good_end(gend_ff),
      .ok_end(ok_ff), .stop_limit(stop_ff), .idle_limit(timeout_ff),
      .refresh_ms(refresh_ff), .motion_threshold(motion_ff),
      .cmd(cmd), .sts(sts),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );
endmodule
`default_nettype wire

/* rtl/pdbd_ctrl.sv */
//------------------------------------------------------------------------------
// pdbd_ctrl
// Sequencer for the per-frame split computation.
//------------------------------------------------------------------------------
`default_nettype none
module pdbd_ctrl
   import pdbd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   output logic         req_tready,
   input  wire sts_type sts,
   output cmd_type      cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = !sts.out_busy;
            if (req_tvalid && !sts.out_busy) begin
               cmd.start = 1'b1;
               if (sts.frame && sts.need_split) state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = ST_SQ;
         end
         ST_SQ:   begin cmd.do_sq = 1'b1;   state_in = ST_CUBE; end
         ST_CUBE: begin cmd.do_cube = 1'b1; state_in = ST_MUL;  end
         ST_MUL:  begin cmd.do_mul = 1'b1;  state_in = ST_OUT;  end
         ST_OUT: begin
            if (!sts.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   property p_start_only_idle;
      @(posedge clock) disable iff (reset) cmd.start |-> state_ff == ST_IDLE;
   endproperty
   a_start_only_idle: assert property (p_start_only_idle) else $error("start outside idle");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      sts.out_busy |-> !req_tready) else $error("accept while output full");
   a_div_to_sq: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && sts.div_done) |=> state_ff == ST_SQ) else $error("div exit");
endmodule
`default_nettype wire

/* rtl/pdbd_datapath.sv */
//------------------------------------------------------------------------------
// pdbd_datapath
// Tick counters, zone classifier, divider, cubic and output register.
//------------------------------------------------------------------------------
`default_nettype none
module pdbd_datapath
   import pdbd_pkg::*;
#(
   parameter int LED_COUNT       = LedCountDefault,
   parameter int FLASH_PERIOD_MS = FlashPeriodDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [15:0] distance,
   input  wire logic [15:0] change_rate,
   input  wire logic [15:0] far_start,
   input  wire logic [15:0] good_start,
   input  wire logic [15:0] good_end,
   input  wire logic [15:0] ok_end,
   input  wire logic [15:0] stop_limit,
   input  wire logic [23:0] idle_limit,
   input  wire logic [9:0]  refresh_ms,
   input  wire logic [14:0] motion_threshold,
   input  wire cmd_type     cmd,
   output sts_type          sts,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata
);
   localparam logic [15:0] SPAN_FULL = 16'(256 * LED_COUNT);
   localparam logic [9:0]  FLASH_P   = 10'(FLASH_PERIOD_MS);
   localparam logic [7:0]  LED_N     = 8'(LED_COUNT);

   logic [9:0]  refresh_ff, refresh_in_v, flash_el_ff, flash_el_in;
   logic        armed_ff, flash_on_ff;
   logic [23:0] idle_ff, idle_inc;
   logic [2:0]  prev_ff;
   logic        valid_ff;
   logic [23:0] data_ff;
   logic [23:0] quick_word;
   logic        stop_entry;

   logic [15:0] mag;
   logic [9:0]  period, flash_inc;
   logic        frame, move, show;
   logic [2:0]  zone;
   logic [15:0] xv, dv;

   assign mag = change_rate[15] ? 16'(-change_rate) : change_rate;
   assign period = (refresh_ms == 10'd0) ? 10'd1 : refresh_ms;
   assign flash_inc = (flash_el_ff < 10'd1023) ? flash_el_ff + 10'd1 : flash_el_ff;
   assign idle_inc = (armed_ff && idle_ff != 24'hFFFFFF) ? idle_ff + 24'd1 : idle_ff;
   assign frame = ({1'b0, refresh_ff} + 11'd1) >= {1'b0, period};
   assign move = mag > {1'b0, motion_threshold};
   assign show = move || !armed_ff || (idle_inc <= idle_limit);

   always_comb begin
      xv = '0; dv = '0;
      if (distance >= far_start) zone = 3'd0;
      else if (distance >= good_start) begin
         zone = 3'd1; xv = distance - good_start; dv = far_start - good_start;
      end else if (distance >= good_end) begin
         zone = 3'd2; xv = distance - good_end; dv = good_start - good_end;
      end else if (distance >= ok_end) begin
         zone = 3'd3; xv = distance - ok_end; dv = good_end - ok_end;
      end else if (distance >= stop_limit) begin
         zone = 3'd4; xv = distance - stop_limit; dv = ok_end - stop_limit;
      end else if (stop_limit > distance) zone = ZONE_STOP;
      else zone = ZONE_ERROR;
   end

   assign sts.frame      = frame;
   assign sts.need_split = show && zone >= 3'd1 && zone <= 3'd4;
   assign sts.out_busy   = valid_ff && !rsp_tready;

   assign stop_entry = prev_ff != ZONE_STOP;

   always_comb begin
      if (!show) quick_word = '0;
      else if (zone == ZONE_FAR) quick_word = {6'd0, 3'd1, 3'd1, 8'd0, zone, 1'b1};
      else if (zone == ZONE_STOP) begin
         if (stop_entry || flash_on_ff)
            quick_word = {6'd0, COLOR_STOP_ON, COLOR_STOP_ON, 8'd0, zone, 1'b1};
         else
            quick_word = {6'd0, COLOR_STOP_OFF, COLOR_STOP_OFF, 8'd0, zone, 1'b1};
      end else quick_word = {6'd0, COLOR_ERROR, COLOR_ERROR, 8'd0, zone, 1'b1};
   end

   // Restoring divider: s = floor(x * 2^16 / dx), x < dx, one quotient bit per cycle.
   logic [15:0] x_ff, d_ff, s_ff;
   logic [16:0] rem_ff, trial;
   logic [4:0]  cnt_ff;
   logic [2:0]  zq_ff;
   logic [31:0] sq_ff;
   logic [17:0] w;
   logic [33:0] cube_ff;
   logic [15:0] t;
   logic signed [16:0] coef;
   logic signed [34:0] prod_ff;
   logic signed [35:0] vsum;
   logic [7:0]  split;

   assign trial = {rem_ff[15:0], 1'b0} - {1'b0, d_ff};
   assign sts.div_done = cnt_ff == 5'd15;
   assign w = 18'd196608 - {1'b0, s_ff, 1'b0};
   assign t = cube_ff[31:16];
   assign coef = $signed({1'b0, SPAN_FULL}) - $signed({1'b0, d_ff});
   assign vsum = $signed({4'd0, x_ff, 16'd0}) + 36'(prod_ff);

   always_comb begin
      if (vsum < 0) split = 8'd0;
      else if (vsum[35:24] > {4'd0, LED_N}) split = LED_N;
      else split = vsum[31:24];
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         x_ff <= xv; d_ff <= dv; rem_ff <= {1'b0, xv}; cnt_ff <= '0; zq_ff <= zone;
      end
      if (cmd.div_step) begin
         cnt_ff <= cnt_ff + 5'd1;
         if (!trial[16] || rem_ff[15]) begin
            rem_ff <= trial;
            s_ff   <= {s_ff[14:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[15:0], 1'b0};
            s_ff   <= {s_ff[14:0], 1'b0};
         end
      end
      if (cmd.do_sq)   sq_ff <= s_ff * s_ff;
      if (cmd.do_cube) cube_ff <= 34'((50'(sq_ff) * 50'(w)) >> 16);
      if (cmd.do_mul)  prod_ff <= coef * $signed({1'b0, t});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         refresh_ff <= '0; armed_ff <= 1'b0; idle_ff <= '0; prev_ff <= '0;
         flash_on_ff <= 1'b0; flash_el_ff <= '0; valid_ff <= 1'b0;
      end else if (cmd.start) begin
         refresh_ff <= frame ? 10'd0 : refresh_in_v;
         if (frame && move) begin
            armed_ff <= 1'b0; idle_ff <= '0;
         end else if (frame && !armed_ff) begin
            armed_ff <= 1'b1; idle_ff <= '0;
         end else begin
            idle_ff <= idle_inc;
         end
         if (frame && show && zone == ZONE_STOP && (stop_entry || flash_el_in >= FLASH_P)) begin
            flash_on_ff <= stop_entry ? 1'b1 : !flash_on_ff;
            flash_el_ff <= '0;
         end else begin
            flash_el_ff <= flash_el_in;
         end
         if (frame && show) prev_ff <= zone;
         valid_ff <= frame && !sts.need_split;
         if (frame && !sts.need_split) data_ff <= quick_word;
      end else if (cmd.finish) begin
         valid_ff <= 1'b1;
         data_ff  <= {6'd0, zq_ff + 3'd1, zq_ff, split, zq_ff, 1'b1};
      end else if (valid_ff && rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   assign flash_el_in  = flash_inc;
   assign refresh_in_v = refresh_ff + 10'd1;
   assign rsp_tvalid   = valid_ff;
   assign rsp_tdata    = data_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_tready) |=> valid_ff && $stable(data_ff)) else $error("lost word");
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> cnt_ff <= 5'd15) else $error("divider overrun");
   a_split_range: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> split <= LED_N) else $error("split out of range");
endmodule
`default_nettype wire
